// ===== sv/cv3_pkg.sv =====
package cv3_pkg;

  localparam int IMG_W_DEF  = 28;
  localparam int IMG_H_DEF  = 28;
  localparam int CNT_W      = 12;
  localparam int FIFO_DEPTH = 4;
  localparam int N_TAP      = 9;
  localparam int ADD_LAT    = 4;
  localparam int COEF_W     = 48;

  localparam logic [1:0] REG_COEF_TOP = 2'd0;
  localparam logic [1:0] REG_COEF_MID = 2'd1;
  localparam logic [1:0] REG_COEF_BOT = 2'd2;

  typedef logic [15:0] half_t;
  typedef logic [31:0] f32_t;

  typedef struct packed {
    logic             last;
    half_t [N_TAP-1:0] win;
  } win_item_t;

  typedef struct packed {
    logic             last;
    half_t [N_TAP-1:0] hp;
  } side_t;

  // fp16 -> fp32, exponent 31 treated as finite
  function automatic f32_t widen_half(half_t h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] mn;
    f32_t       r;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn = 10'(m << (4'd10 - p));
    if (e != 5'd0) begin
      r = {s, 8'({3'b0, e}) + 8'd112, m, 13'b0};
    end else if (m == 10'd0) begin
      r = {s, 31'b0};
    end else begin
      r = {s, 8'd103 + 8'({4'b0, p}), mn, 13'b0};
    end
    return r;
  endfunction

  // fp32 -> fp16, ties away, flush below, saturate above
  function automatic half_t narrow_f32(f32_t x);
    logic [31:0] b;
    logic [7:0]  e;
    logic [22:0] m;
    logic [15:0] r;
    logic [23:0] t;
    logic [23:0] tt;
    logic [4:0]  sh;
    b  = x + 32'h0000_1000;
    e  = b[30:23];
    m  = b[22:0];
    r  = {b[31], 15'b0};
    t  = 24'h7ff000 + {1'b0, m};
    sh = 5'(8'd125 - e);
    tt = (t >> sh) + 24'd1;
    if (e > 8'd112) r = r | {1'b0, 5'(e - 8'd112), m[22:13]};
    if (e < 8'd113 && e > 8'd101) r = r | 16'(tt >> 1);
    if (e > 8'd143) r = r | 16'h7fff;
    return r;
  endfunction

  function automatic logic [4:0] lead_zeros28(logic [27:0] v);
    logic [4:0] lz;
    lz = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) lz = 5'(27 - i);
    end
    return lz;
  endfunction

endpackage

// ===== sv/conv3x3_fp16_valid.sv =====
// channel  dir  payload                              handshake
// in       in   in_pixel[15:0]                       in_valid / in_stall
// out      out  out_conv_value[15:0], out_frame_last out_valid / out_stall
// cfg      in   cfg_index[1:0], cfg_data[47:0]       cfg_we
//
// One pixel per cycle while in_stall is low; the front updates window and line
// shift registers as each word is accepted and queues full windows.
// The back pipeline has one product stage, one rounding stage, and nine
// chained 4-stage adders.
// Synchronous reset clears counters, queue and pipeline valids.
// A result held by out_stall freezes the whole back pipeline; the input
// stalls only when the 4-entry queue is full.
module conv3x3_fp16_valid
  import cv3_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMG_W_DEF,
  parameter int IMAGE_HEIGHT = IMG_H_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_conv_value,
  output logic              out_frame_last,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  logic [2:0][COEF_W-1:0] coef_r;
  logic                   q_full, q_push, q_valid, q_pop;
  win_item_t              q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_TOP: coef_r[0] <= cfg_data;
        REG_COEF_MID: coef_r[1] <= cfg_data;
        REG_COEF_BOT: coef_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  cv3_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  cv3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_out)
  );

  cv3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef           (coef_r),
    .q_valid        (q_valid),
    .q_item         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_conv_value (out_conv_value),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== sv/cv3_front.sv =====
module cv3_front
  import cv3_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMG_W_DEF,
  parameter int IMAGE_HEIGHT = IMG_H_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  half_t     in_pixel,
  input  logic      q_full,
  output logic      q_push,
  output win_item_t q_item
);

  localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(IMAGE_WIDTH - 1);
  localparam logic [CNT_W-1:0] ROW_LAST = CNT_W'(IMAGE_HEIGHT - 1);

  logic [CNT_W-1:0]   col_r, row_r;
  half_t              line_up_r  [IMAGE_WIDTH];
  half_t              line_mid_r [IMAGE_WIDTH];
  half_t [N_TAP-1:0]  win_r, win_nxt;
  logic               acc;
  half_t              upper, middle;

  assign in_stall = q_full;
  assign acc      = in_valid & ~q_full;
  assign upper    = line_up_r[IMAGE_WIDTH-1];
  assign middle   = line_mid_r[IMAGE_WIDTH-1];

  always_comb begin
    win_nxt    = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = upper;
    win_nxt[5] = middle;
    win_nxt[8] = in_pixel;
  end

  assign q_push = acc && (row_r >= CNT_W'(2)) && (col_r >= CNT_W'(2));
  assign q_item = '{last: (row_r == ROW_LAST) && (col_r == COL_LAST), win: win_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (col_r == COL_LAST) begin
        col_r <= '0;
        row_r <= (row_r == ROW_LAST) ? '0 : row_r + CNT_W'(1);
      end else begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      win_r         <= win_nxt;
      line_up_r[0]  <= middle;
      line_mid_r[0] <= in_pixel;
      for (int i = 1; i < IMAGE_WIDTH; i++) begin
        line_up_r[i]  <= line_up_r[i-1];
        line_mid_r[i] <= line_mid_r[i-1];
      end
    end
  end

endmodule

// ===== sv/cv3_fifo.sv =====
module cv3_fifo
  import cv3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  win_item_t push_item,
  output logic      full,
  output logic      pop_valid,
  input  logic      pop,
  output win_item_t pop_item
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  win_item_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem[rd_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= rd_r + PTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (PTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_item;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("queue count above depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + (PTR_W+1)'(1))
    else $error("queue count not incremented");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_r - rd_r) == PTR_W'(cnt_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== sv/cv3_fadd.sv =====
module cv3_fadd
  import cv3_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  half_t a,
  input  half_t b,
  output half_t sum
);

  f32_t        fa, fb, fbig, fsml;
  logic        swap;
  logic [7:0]  dlt;
  logic [23:0] mb, ms;
  logic [26:0] wide, al, mask;
  logic        st;

  logic        a_sign_r, a_sub_r, a_bz_r, a_zs_r;
  logic [7:0]  a_exp_r;
  logic [26:0] a_big_r, a_al_r;

  logic        b_sign_r, b_bz_r, b_zs_r;
  logic [7:0]  b_exp_r;
  logic [27:0] b_sum_r;
  logic [4:0]  b_lz_r;
  logic [27:0] s_nxt;

  f32_t        c_f_r, c_nxt;
  logic [26:0] n;
  logic [7:0]  ex;
  logic [24:0] m25;
  logic        up;

  half_t       d_r;

  always_comb begin
    fa   = widen_half(a);
    fb   = widen_half(b);
    swap = fb[30:0] > fa[30:0];
    fbig = swap ? fb : fa;
    fsml = swap ? fa : fb;
    mb   = (fbig[30:23] == 8'd0) ? 24'd0 : {1'b1, fbig[22:0]};
    ms   = (fsml[30:23] == 8'd0) ? 24'd0 : {1'b1, fsml[22:0]};
    dlt  = fbig[30:23] - fsml[30:23];
    wide = {ms, 3'b0};
    mask = (27'd1 << dlt[4:0]) - 27'd1;
    if (dlt >= 8'd27) begin
      al = '0;
      st = |ms;
    end else begin
      al = wide >> dlt[4:0];
      st = |(wide & mask);
    end
    al[0] = al[0] | st;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sign_r <= fbig[31];
      a_sub_r  <= fa[31] ^ fb[31];
      a_bz_r   <= (fa[30:23] == 8'd0) && (fb[30:23] == 8'd0);
      a_zs_r   <= fa[31] & fb[31];
      a_exp_r  <= fbig[30:23];
      a_big_r  <= {mb, 3'b0};
      a_al_r   <= al;
    end
  end

  assign s_nxt = a_sub_r ? ({1'b0, a_big_r} - {1'b0, a_al_r})
                         : ({1'b0, a_big_r} + {1'b0, a_al_r});

  always_ff @(posedge clk) begin
    if (en) begin
      b_sign_r <= a_sign_r;
      b_bz_r   <= a_bz_r;
      b_zs_r   <= a_zs_r;
      b_exp_r  <= a_exp_r;
      b_sum_r  <= s_nxt;
      b_lz_r   <= lead_zeros28(s_nxt);
    end
  end

  always_comb begin
    if (b_sum_r[27]) begin
      n  = {b_sum_r[27:2], b_sum_r[1] | b_sum_r[0]};
      ex = b_exp_r + 8'd1;
    end else begin
      n  = 27'(b_sum_r[26:0] << (b_lz_r - 5'd1));
      ex = b_exp_r - 8'({3'b0, b_lz_r - 5'd1});
    end
    up  = n[2] & (n[1] | n[0] | n[3]);
    m25 = {1'b0, n[26:3]} + 25'(up);
    if (b_bz_r) begin
      c_nxt = {b_zs_r, 31'b0};
    end else if (b_sum_r == 28'd0) begin
      c_nxt = '0;
    end else if (m25[24]) begin
      c_nxt = {b_sign_r, ex + 8'd1, m25[23:1]};
    end else begin
      c_nxt = {b_sign_r, ex, m25[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_f_r <= c_nxt;
      d_r   <= narrow_f32(c_f_r);
    end
  end

  assign sum = d_r;

endmodule

// ===== sv/cv3_back.sv =====
module cv3_back
  import cv3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2:0][COEF_W-1:0] coef,
  input  logic                  q_valid,
  input  win_item_t             q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output half_t                 out_conv_value,
  output logic                  out_frame_last
);

  localparam int NPOS = ADD_LAT * N_TAP;

  logic              en;
  logic              v1_r;
  logic              last1_r;
  f32_t              prod_r [N_TAP];
  f32_t              prod_nxt [N_TAP];
  logic              v_r [NPOS+1];
  side_t             side_r [NPOS+1];
  half_t             psum [N_TAP];

  assign en    = ~(v_r[NPOS] & out_stall);
  assign q_pop = q_valid & en;

  always_comb begin
    for (int k = 0; k < N_TAP; k++) begin
      f32_t        fp, fc;
      logic [10:0] sp, sc;
      logic [21:0] p;
      logic [9:0]  ex;
      fp = widen_half(q_item.win[k]);
      fc = widen_half(coef[k/3][16*(k%3) +: 16]);
      sp = {1'b1, fp[22:13]};
      sc = {1'b1, fc[22:13]};
      p  = sp * sc;
      ex = {2'b0, fp[30:23]} + {2'b0, fc[30:23]} - 10'd127;
      if (fp[30:23] == 8'd0 || fc[30:23] == 8'd0) begin
        prod_nxt[k] = {fp[31] ^ fc[31], 31'b0};
      end else if (p[21]) begin
        prod_nxt[k] = {fp[31] ^ fc[31], 8'(ex + 10'd1), p[20:0], 2'b0};
      end else begin
        prod_nxt[k] = {fp[31] ^ fc[31], ex[7:0], p[19:0], 3'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      for (int i = 0; i <= NPOS; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v1_r   <= q_valid;
      v_r[0] <= v1_r;
      for (int i = 1; i <= NPOS; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last1_r <= q_item.last;
      for (int k = 0; k < N_TAP; k++) begin
        prod_r[k]        <= prod_nxt[k];
        side_r[0].hp[k]  <= narrow_f32(prod_r[k]);
      end
      side_r[0].last <= last1_r;
      for (int i = 1; i <= NPOS; i++) side_r[i] <= side_r[i-1];
    end
  end

  for (genvar k = 0; k < N_TAP; k++) begin : g_term
    cv3_fadd u_fadd (
      .clk (clk),
      .en  (en),
      .a   ((k == 0) ? 16'h0000 : psum[(k == 0) ? 0 : k-1]),
      .b   (side_r[ADD_LAT*k].hp[k]),
      .sum (psum[k])
    );
  end

  assign out_valid      = v_r[NPOS];
  assign out_conv_value = psum[N_TAP-1];
  assign out_frame_last = side_r[NPOS].last;

endmodule

// ===== bench/tb_conv3x3_fp16_valid.sv =====
`timescale 1ns / 1ps

module tb_conv3x3_fp16_valid;
  import cv3_pkg::*;

  localparam int W = IMG_W_DEF;
  localparam int H = IMG_H_DEF;
  localparam int PIPE_LAT = 38;
  localparam int WDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    half_t value;
    logic  last;
  } conv_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [15:0] out_conv_value;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  conv3x3_fp16_valid uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [COEF_W-1:0] coef_q [3];
  half_t line_q [2*W];
  half_t win_q [9];
  int col_q, row_q;
  conv_word_t pending_q [$];

  int errors = 0;
  int n_in = 0, n_out = 0, n_last = 0;
  int quiet = 0;
  bit idle_on = 1'b1;
  int hold_req = 0;

  task automatic report(string what, half_t got, half_t want);
    errors++;
    $display("mismatch %s: got %h want %h (word %0d)", what, got, want, n_out);
  endtask

  function automatic f32_t half_to_f32(half_t h);
    logic [3:0] p;
    logic [9:0] m;
    m = h[9:0];
    p = 4'd0;
    if (h[14:10] != 0)
      return {h[15], 8'(h[14:10]) + 8'd112, m, 13'b0};
    if (m == 0)
      return {h[15], 31'b0};
    for (int i = 0; i < 10; i++) if (m[i]) p = 4'(i);
    return {h[15], 8'd103 + 8'(p), 10'(m << (10 - p)), 13'b0};
  endfunction

  function automatic half_t f32_to_half(f32_t x);
    logic [31:0] b, e, m, r;
    b = x + 32'h0000_1000;
    e = (b >> 23) & 32'hff;
    m = b & 32'h007f_ffff;
    r = (b & 32'h8000_0000) >> 16;
    if (e > 112) r = r | (((e - 112) << 10) & 32'h7c00) | (m >> 13);
    if (e < 113 && e > 101) r = r | ((((32'h007f_f000 + m) >> (125 - e)) + 1) >> 1);
    if (e > 143) r = r | 32'h7fff;
    return r[15:0];
  endfunction

  function automatic real f32_real(f32_t f);
    if (f[30:23] == 0) return $bitstoreal({f[31], 63'b0});
    return $bitstoreal({f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'b0});
  endfunction

  // round a double to float32, nearest-even; operands here stay normal
  function automatic f32_t real_f32(real x);
    logic [63:0] d;
    logic [30:0] keep;
    logic [28:0] rest;
    d = $realtobits(x);
    if (d[62:52] == 0) return {d[63], 31'b0};
    keep = {8'(d[62:52] - 11'd896), d[51:29]};
    rest = d[28:0];
    if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && keep[0])) keep = keep + 31'd1;
    return {d[63], keep};
  endfunction

  function automatic half_t conv_window();
    half_t acc, hp, c;
    acc = 16'h0000;
    for (int k = 0; k < 9; k++) begin
      c = coef_q[k/3][16*(k%3) +: 16];
      hp = f32_to_half(real_f32(f32_real(half_to_f32(win_q[k])) *
                                f32_real(half_to_f32(c))));
      acc = f32_to_half(real_f32(f32_real(half_to_f32(acc)) +
                                 f32_real(half_to_f32(hp))));
    end
    return acc;
  endfunction

  task automatic predict_pixel(half_t px);
    conv_word_t w;
    for (int r = 0; r < 3; r++) begin
      win_q[r*3] = win_q[r*3+1];
      win_q[r*3+1] = win_q[r*3+2];
    end
    win_q[2] = line_q[col_q];
    win_q[5] = line_q[W+col_q];
    win_q[8] = px;
    line_q[col_q] = line_q[W+col_q];
    line_q[W+col_q] = px;
    if (row_q >= 2 && col_q >= 2) begin
      w.value = conv_window();
      w.last = (row_q == H-1) && (col_q == W-1);
      pending_q.push_back(w);
    end
    if (col_q + 1 >= W) begin
      col_q = 0;
      row_q = (row_q + 1 >= H) ? 0 : row_q + 1;
    end else begin
      col_q++;
    end
  endtask

  function automatic int draw_gap();
    if (!idle_on) return 0;
    return $urandom_range(0, 8);
  endfunction

  // caller sits at a falling edge; returns at a falling edge, valid still high
  task automatic send_pixel(half_t px);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pixel = px;
    do @(posedge clk); while (in_stall);
    predict_pixel(px);
    n_in++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [COEF_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx != REG_UNUSED) coef_q[idx] = val;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  function automatic half_t rand_pixel();
    half_t ext [10] = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff, 16'h7c00,
                        16'hfc00, 16'h0001, 16'h8001, 16'h03ff, 16'h3c00};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return half_t'($urandom);
      4: return ext[$urandom_range(0, 9)];
      default: return {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coefs(int kind);
    logic [COEF_W-1:0] v;
    for (int j = 0; j < 3; j++) begin
      case (kind)
        0: v[16*j +: 16] = 16'h0000;
        1: v[16*j +: 16] = 16'hffff;
        2: v[16*j +: 16] = {1'($urandom), 5'($urandom_range(12, 16)), 10'($urandom)};
        3: v[16*j +: 16] = half_t'($urandom);
        default: v[16*j +: 16] = {1'($urandom), 5'd0, 10'($urandom)};
      endcase
    end
    return v;
  endfunction

  // receiver: check at rising edge, drive stall at falling edge
  initial begin : receiver
    int gap;
    conv_word_t w;
    gap = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("unexpected word %h", out_conv_value);
        end else begin
          w = pending_q.pop_front();
          if (out_conv_value !== w.value) report("conv_value", out_conv_value, w.value);
          if (out_frame_last !== w.last)
            report("frame_last", 16'(out_frame_last), 16'(w.last));
        end
        n_out++;
        if (out_frame_last) n_last++;
        gap = draw_gap();
      end
      @(negedge clk);
      if (hold_req > 0) begin
        out_stall = 1'b1;
        hold_req--;
      end else if (gap > 0) begin
        out_stall = 1'b1;
        gap--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
        quiet = 0;
      else
        quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  half_t directed [25] = '{
    16'h0000, 16'h8000, 16'h7fff, 16'hffff, 16'h7c00, 16'hfc00, 16'h7e00,
    16'h0001, 16'h8001, 16'h03ff, 16'h83ff, 16'h0400, 16'h3c00, 16'hbc00,
    16'h7bff, 16'hfbff, 16'h5555, 16'haaaa, 16'h3555, 16'h0200, 16'h3800,
    16'h4000, 16'hc000, 16'h1234, 16'h7fff};

  initial begin : stimulus
    int kind;
    for (int i = 0; i < 3; i++) coef_q[i] = '0;
    for (int i = 0; i < 2*W; i++) line_q[i] = '0;
    for (int i = 0; i < 9; i++) win_q[i] = '0;
    col_q = 0;
    row_q = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset coefficients are zero, so every word here must be +0
    foreach (directed[i]) send_pixel(directed[i]);
    foreach (pending_q[i])
      if (pending_q[i].value !== 16'h0000) report("zero kernel", pending_q[i].value, 16'h0);
    wait_drained();

    write_reg(REG_UNUSED, rand_coefs(3));
    for (int ph = 0; ph < 8; ph++) begin
      kind = (ph < 5) ? ph : $urandom_range(2, 4);
      write_reg(REG_COEF_TOP, rand_coefs(kind));
      write_reg(REG_COEF_MID, rand_coefs(kind == 1 ? 1 : $urandom_range(2, 4)));
      write_reg(REG_COEF_BOT, rand_coefs(kind));
      idle_on = (ph % 3 != 1);
      if (ph == 3) hold_req = HOLD_CYCLES;
      repeat (185) send_pixel(rand_pixel());
      wait_drained();
    end

    $display("sent %0d pixels, checked %0d words, %0d frame ends, 8 kernel settings",
             n_in, n_out, n_last);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
